FILE: rtl/core/ps2mpt_pkg.sv
`default_nettype none

package ps2mpt_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 64;

   localparam int POS_W  = 13;
   localparam int DIM_W  = 14;
   localparam int BYTE_W = 8;
   localparam int BTN_W  = 3;
   localparam int DX_W   = 8;
   localparam int DY_W   = 9;

   localparam logic [DIM_W-1:0] DIM_MAX      = 14'd8192;
   localparam logic [DIM_W-1:0] RESET_WIDTH  = 14'd1280;
   localparam logic [DIM_W-1:0] RESET_HEIGHT = 14'd720;
   localparam logic [POS_W-1:0] RESET_POS_X  = 13'd640;
   localparam logic [POS_W-1:0] RESET_POS_Y  = 13'd360;

   localparam logic [BYTE_W-1:0] SYNC_MASK = 8'h08;
   localparam logic [BYTE_W-1:0] XOVF_MASK = 8'h40;
   localparam logic [BYTE_W-1:0] YOVF_MASK = 8'h80;
   localparam logic [BYTE_W-1:0] BTN_MASK  = 8'h07;

   localparam int CSR_INDEX_W = 1;

   typedef enum logic [1:0] {
      OP_DATA     = 2'd0,
      OP_READ     = 2'd1,
      OP_RECENTER = 2'd2
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SCREEN_WIDTH  = 1'b0,
      CSR_SCREEN_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      PKT_FIRST  = 2'd0,
      PKT_SECOND = 2'd1,
      PKT_THIRD  = 2'd2
   } packet_state_type;

   typedef struct packed {
      logic [POS_W-1:0]       x;
      logic [POS_W-1:0]       y;
      logic signed [DX_W-1:0] dx;
      logic signed [DY_W-1:0] dy;
      logic [BTN_W-1:0]       buttons;
   } event_type;

   typedef struct packed {
      logic             pop;
      logic [POS_W-1:0] pointer_x;
      logic [POS_W-1:0] pointer_y;
      logic [BTN_W-1:0] pointer_buttons;
      logic             packet_done;
      logic             event_dropped;
   } stage_type;

   typedef struct packed {
      logic             event_valid;
      event_type        evt;
      logic [POS_W-1:0] pointer_x;
      logic [POS_W-1:0] pointer_y;
      logic [BTN_W-1:0] pointer_buttons;
      logic             packet_done;
      logic             event_dropped;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/core/ps2_mouse_packet_tracker.sv
// Response path: an accepted request passes one update stage, whose event read lands
//    in a registered RAM output, then a 2-entry response queue.
// Throughput: one transaction per cycle while req_ready is high; the packet, pointer and
//    ring updates finish in the acceptance cycle, and the response queue absorbs a sink stall.
// Reset: synchronous, active high; screen 1280x720, pointer at (640,360), ring empty.
`default_nettype none

module ps2_mouse_packet_tracker #(
   parameter int QUEUE_DEPTH = ps2mpt_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,

   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [1:0]                             req_opcode,
   input  wire logic [ps2mpt_pkg::BYTE_W-1:0]          req_data_byte,

   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic                                        rsp_event_valid,
   output logic [ps2mpt_pkg::POS_W-1:0]                rsp_event_x,
   output logic [ps2mpt_pkg::POS_W-1:0]                rsp_event_y,
   output logic signed [ps2mpt_pkg::DX_W-1:0]          rsp_event_dx,
   output logic signed [ps2mpt_pkg::DY_W-1:0]          rsp_event_dy,
   output logic [ps2mpt_pkg::BTN_W-1:0]                rsp_event_buttons,
   output logic [ps2mpt_pkg::POS_W-1:0]                rsp_pointer_x,
   output logic [ps2mpt_pkg::POS_W-1:0]                rsp_pointer_y,
   output logic [ps2mpt_pkg::BTN_W-1:0]                rsp_pointer_buttons,
   output logic                                        rsp_packet_done,
   output logic                                        rsp_event_dropped,

   input  wire logic                                   csr_write_enable,
   input  wire logic [ps2mpt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [ps2mpt_pkg::DIM_W-1:0]           csr_write_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   // ---------------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------------
   logic [ps2mpt_pkg::DIM_W-1:0]   width_ff, width_in;
   logic [ps2mpt_pkg::DIM_W-1:0]   height_ff, height_in;
   ps2mpt_pkg::packet_state_type   pkt_state_ff, pkt_state_in;
   logic [ps2mpt_pkg::BYTE_W-1:0]  first_byte_ff, first_byte_in;
   logic [ps2mpt_pkg::BYTE_W-1:0]  second_byte_ff, second_byte_in;
   logic [ps2mpt_pkg::POS_W-1:0]   pos_x_ff, pos_x_in;
   logic [ps2mpt_pkg::POS_W-1:0]   pos_y_ff, pos_y_in;
   logic [ps2mpt_pkg::BTN_W-1:0]   buttons_ff, buttons_in;
   logic [PTR_W-1:0]               wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]               rd_ptr_ff, rd_ptr_in;

   ps2mpt_pkg::event_type          event_store_ff [QUEUE_DEPTH];
   ps2mpt_pkg::event_type          read_data_ff;

   logic                           s1_valid_ff, s1_valid_in;
   ps2mpt_pkg::stage_type          s1_ff, s1_in;

   ps2mpt_pkg::result_type         rsp_queue_ff [2];
   logic                           rsp_head_ff, rsp_head_in;
   logic                           rsp_tail_ff, rsp_tail_in;
   logic [1:0]                     rsp_count_ff, rsp_count_in;

   // ---------------------------------------------------------------------------
   // Handshakes
   // ---------------------------------------------------------------------------
   logic accept;
   logic data_accept;
   logic read_accept;
   logic recenter_accept;
   logic rsp_take;
   logic [1:0] occupancy;

   // Count what is in flight: the update stage plus queued responses. Accept
   // while there is room, or while the sink takes the head in this cycle, so
   // that the update stage can always drain into the queue.
   assign occupancy = rsp_count_ff + {1'b0, s1_valid_ff};
   assign req_ready = (occupancy < 2'd2) || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (rsp_count_ff != 2'd0);
   assign rsp_take  = rsp_valid && rsp_ready;

   assign data_accept     = accept && (req_opcode == ps2mpt_pkg::OP_DATA);
   assign read_accept     = accept && (req_opcode == ps2mpt_pkg::OP_READ);
   assign recenter_accept = accept && (req_opcode == ps2mpt_pkg::OP_RECENTER);

   // ---------------------------------------------------------------------------
   // Packet assembly: next state
   // ---------------------------------------------------------------------------
   logic sync_ok;
   assign sync_ok = ((req_data_byte & ps2mpt_pkg::SYNC_MASK) != '0);

   always_comb begin
      pkt_state_in = pkt_state_ff;
      if (data_accept) begin
         case (pkt_state_ff)
            ps2mpt_pkg::PKT_FIRST: begin
               if (sync_ok) begin
                  pkt_state_in = ps2mpt_pkg::PKT_SECOND;
               end
            end
            ps2mpt_pkg::PKT_SECOND: pkt_state_in = ps2mpt_pkg::PKT_THIRD;
            ps2mpt_pkg::PKT_THIRD:  pkt_state_in = ps2mpt_pkg::PKT_FIRST;
            default:                pkt_state_in = ps2mpt_pkg::PKT_FIRST;
         endcase
      end
   end

   // Packet assembly: outputs
   logic capture_first;
   logic capture_second;
   logic packet_complete;

   always_comb begin
      capture_first   = 1'b0;
      capture_second  = 1'b0;
      packet_complete = 1'b0;
      case (pkt_state_ff)
         ps2mpt_pkg::PKT_FIRST:  capture_first   = data_accept && sync_ok;
         ps2mpt_pkg::PKT_SECOND: capture_second  = data_accept;
         ps2mpt_pkg::PKT_THIRD:  packet_complete = data_accept;
         default: begin
            capture_first   = 1'b0;
            capture_second  = 1'b0;
            packet_complete = 1'b0;
         end
      endcase
   end

   assign first_byte_in  = capture_first  ? req_data_byte : first_byte_ff;
   assign second_byte_in = capture_second ? req_data_byte : second_byte_ff;

   // ---------------------------------------------------------------------------
   // Deltas: dx from byte 1, dy is the negated byte 2 (screen direction).
   // An overflow flag in byte 0 zeroes its delta.
   // ---------------------------------------------------------------------------
   logic signed [ps2mpt_pkg::DX_W-1:0] delta_x;
   logic signed [ps2mpt_pkg::DY_W-1:0] delta_y;

   always_comb begin
      delta_x = $signed(second_byte_ff);
      delta_y = -$signed({req_data_byte[7], req_data_byte});
      if ((first_byte_ff & ps2mpt_pkg::XOVF_MASK) != '0) begin
         delta_x = '0;
      end
      if ((first_byte_ff & ps2mpt_pkg::YOVF_MASK) != '0) begin
         delta_y = '0;
      end
   end

   // Clamp a signed candidate position into [0, size-1].
   function automatic logic [ps2mpt_pkg::POS_W-1:0] clamp_axis(
      input logic signed [ps2mpt_pkg::POS_W+1:0] value,
      input logic [ps2mpt_pkg::DIM_W-1:0]        size
   );
      logic [ps2mpt_pkg::DIM_W-1:0] top;
      logic [ps2mpt_pkg::POS_W-1:0] result;
      top = size - 1'b1;
      if (value < 0) begin
         result = '0;
      end else if (value > $signed({1'b0, top})) begin
         result = top[ps2mpt_pkg::POS_W-1:0];
      end else begin
         result = value[ps2mpt_pkg::POS_W-1:0];
      end
      return result;
   endfunction

   logic signed [ps2mpt_pkg::POS_W+1:0] moved_x;
   logic signed [ps2mpt_pkg::POS_W+1:0] moved_y;
   logic [ps2mpt_pkg::POS_W-1:0]        packet_x;
   logic [ps2mpt_pkg::POS_W-1:0]        packet_y;
   logic [ps2mpt_pkg::BTN_W-1:0]        packet_buttons;

   assign moved_x = $signed({2'b00, pos_x_ff})
                  + $signed({{(ps2mpt_pkg::POS_W+2-ps2mpt_pkg::DX_W){delta_x[7]}}, delta_x});
   assign moved_y = $signed({2'b00, pos_y_ff})
                  + $signed({{(ps2mpt_pkg::POS_W+2-ps2mpt_pkg::DY_W){delta_y[8]}}, delta_y});
   assign packet_x       = clamp_axis(moved_x, width_ff);
   assign packet_y       = clamp_axis(moved_y, height_ff);
   assign packet_buttons = ps2mpt_pkg::BTN_W'(first_byte_ff & ps2mpt_pkg::BTN_MASK);

   // ---------------------------------------------------------------------------
   // Event ring: one slot stays empty, so a full ring holds QUEUE_DEPTH-1 events.
   // ---------------------------------------------------------------------------
   logic [PTR_W-1:0] wr_ptr_next;
   logic [PTR_W-1:0] rd_ptr_next;
   logic             ring_full;
   logic             ring_empty;
   logic             push;
   logic             pop;

   assign wr_ptr_next = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_next = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
   assign ring_full   = (wr_ptr_next == rd_ptr_ff);
   assign ring_empty  = (wr_ptr_ff == rd_ptr_ff);
   assign push        = packet_complete && !ring_full;
   assign pop         = read_accept && !ring_empty;
   assign wr_ptr_in   = push ? wr_ptr_next : wr_ptr_ff;
   assign rd_ptr_in   = pop  ? rd_ptr_next : rd_ptr_ff;

   ps2mpt_pkg::event_type new_event;

   always_comb begin
      new_event.x       = packet_x;
      new_event.y       = packet_y;
      new_event.dx      = delta_x;
      new_event.dy      = delta_y;
      new_event.buttons = packet_buttons;
   end

   // A pop never hits the slot being written in the same cycle: it needs a
   // non-empty ring, and the write goes to the free slot.
   always_ff @(posedge clock) begin
      if (push) begin
         event_store_ff[wr_ptr_ff] <= new_event;
      end
      if (pop) begin
         read_data_ff <= event_store_ff[rd_ptr_ff];
      end
   end

   // ---------------------------------------------------------------------------
   // Screen registers: drop a zero write, saturate above the largest screen,
   // and pull the pointer into the new bounds without recentering.
   // ---------------------------------------------------------------------------
   logic [ps2mpt_pkg::DIM_W-1:0] csr_value;
   logic                         csr_effective;
   logic [ps2mpt_pkg::DIM_W-1:0] width_top;
   logic [ps2mpt_pkg::DIM_W-1:0] height_top;

   assign csr_value     = (csr_write_data > ps2mpt_pkg::DIM_MAX) ? ps2mpt_pkg::DIM_MAX
                                                                 : csr_write_data;
   assign csr_effective = csr_write_enable && (csr_value != '0);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_effective) begin
         case (csr_index)
            ps2mpt_pkg::CSR_SCREEN_WIDTH:  width_in  = csr_value;
            ps2mpt_pkg::CSR_SCREEN_HEIGHT: height_in = csr_value;
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   assign width_top  = width_in  - 1'b1;
   assign height_top = height_in - 1'b1;

   // ---------------------------------------------------------------------------
   // Pointer and buttons
   // ---------------------------------------------------------------------------
   always_comb begin
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      buttons_in = buttons_ff;
      if (csr_effective) begin
         if ({1'b0, pos_x_ff} > width_top) begin
            pos_x_in = width_top[ps2mpt_pkg::POS_W-1:0];
         end
         if ({1'b0, pos_y_ff} > height_top) begin
            pos_y_in = height_top[ps2mpt_pkg::POS_W-1:0];
         end
      end else if (packet_complete) begin
         pos_x_in   = packet_x;
         pos_y_in   = packet_y;
         buttons_in = packet_buttons;
      end else if (recenter_accept) begin
         pos_x_in = width_ff[ps2mpt_pkg::DIM_W-1:1];
         pos_y_in = height_ff[ps2mpt_pkg::DIM_W-1:1];
      end
   end

   // ---------------------------------------------------------------------------
   // Update stage: hold the step's result until the RAM read data is there.
   // ---------------------------------------------------------------------------
   assign s1_valid_in = accept;

   always_comb begin
      s1_in.pop             = pop;
      s1_in.pointer_x       = pos_x_in;
      s1_in.pointer_y       = pos_y_in;
      s1_in.pointer_buttons = buttons_in;
      s1_in.packet_done     = packet_complete;
      s1_in.event_dropped   = packet_complete && ring_full;
   end

   ps2mpt_pkg::result_type s1_result;

   always_comb begin
      s1_result.event_valid     = s1_ff.pop;
      s1_result.evt             = s1_ff.pop ? read_data_ff : '0;
      s1_result.pointer_x       = s1_ff.pointer_x;
      s1_result.pointer_y       = s1_ff.pointer_y;
      s1_result.pointer_buttons = s1_ff.pointer_buttons;
      s1_result.packet_done     = s1_ff.packet_done;
      s1_result.event_dropped   = s1_ff.event_dropped;
   end

   // ---------------------------------------------------------------------------
   // Response queue: two entries, so the request side keeps going while a
   // finished transaction waits for the sink.
   // ---------------------------------------------------------------------------
   assign rsp_tail_in  = s1_valid_ff ? ~rsp_tail_ff : rsp_tail_ff;
   assign rsp_head_in  = rsp_take    ? ~rsp_head_ff : rsp_head_ff;
   assign rsp_count_in = rsp_count_ff + {1'b0, s1_valid_ff} - {1'b0, rsp_take};

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rsp_queue_ff[rsp_tail_ff] <= s1_result;
      end
   end

   ps2mpt_pkg::result_type rsp_head;
   assign rsp_head = rsp_queue_ff[rsp_head_ff];

   assign rsp_event_valid     = rsp_head.event_valid;
   assign rsp_event_x         = rsp_head.evt.x;
   assign rsp_event_y         = rsp_head.evt.y;
   assign rsp_event_dx        = rsp_head.evt.dx;
   assign rsp_event_dy        = rsp_head.evt.dy;
   assign rsp_event_buttons   = rsp_head.evt.buttons;
   assign rsp_pointer_x       = rsp_head.pointer_x;
   assign rsp_pointer_y       = rsp_head.pointer_y;
   assign rsp_pointer_buttons = rsp_head.pointer_buttons;
   assign rsp_packet_done     = rsp_head.packet_done;
   assign rsp_event_dropped   = rsp_head.event_dropped;

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= ps2mpt_pkg::RESET_WIDTH;
         height_ff      <= ps2mpt_pkg::RESET_HEIGHT;
         pkt_state_ff   <= ps2mpt_pkg::PKT_FIRST;
         first_byte_ff  <= '0;
         second_byte_ff <= '0;
         pos_x_ff       <= ps2mpt_pkg::RESET_POS_X;
         pos_y_ff       <= ps2mpt_pkg::RESET_POS_Y;
         buttons_ff     <= '0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         s1_valid_ff    <= 1'b0;
         rsp_head_ff    <= 1'b0;
         rsp_tail_ff    <= 1'b0;
         rsp_count_ff   <= '0;
      end else begin
         width_ff       <= width_in;
         height_ff      <= height_in;
         pkt_state_ff   <= pkt_state_in;
         first_byte_ff  <= first_byte_in;
         second_byte_ff <= second_byte_in;
         pos_x_ff       <= pos_x_in;
         pos_y_ff       <= pos_y_in;
         buttons_ff     <= buttons_in;
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_head_ff    <= rsp_head_in;
         rsp_tail_ff    <= rsp_tail_in;
         rsp_count_ff   <= rsp_count_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      occupancy <= 2'd2)
      else $error("response queue overrun");

   a_pop_follows_read: assert property (@(posedge clock) disable iff (reset)
      (read_accept && !ring_empty) |=> (s1_valid_ff && s1_ff.pop))
      else $error("read on non-empty ring did not pop");

   a_drop_needs_packet: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ff.event_dropped) |-> s1_ff.packet_done)
      else $error("drop flagged without a completed packet");

   a_done_not_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_packet_done && rsp_event_valid))
      else $error("packet and pop in one transaction");

endmodule

`default_nettype wire

FILE: dv/ps2_mouse_packet_tracker_test.sv
`default_nettype none

module ps2_mouse_packet_tracker_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ps2mpt_pkg::*;

   // Opcode 3 has no member in the package enum; the block treats it as a no-op.
   localparam logic [1:0] OP_NONE = 2'd3;

   localparam int QDEPTH        = DEFAULT_QUEUE_DEPTH;
   localparam int PHASE_ITEMS   = 165;
   localparam int LAST_PHASE    = 6;
   // Covers the update stage plus the response queue; leave some margin.
   localparam int LATENCY_SLACK = 6;
   localparam int CYCLE_LIMIT   = 400000;

   // Clock and reset
   logic clock = 1'b0;
   logic reset;

   always #1 clock = ~clock;

   // Block ports
   logic                  req_valid;
   logic                  req_ready;
   logic [1:0]            req_opcode;
   logic [BYTE_W-1:0]     req_data_byte;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_event_valid;
   logic [POS_W-1:0]      rsp_event_x;
   logic [POS_W-1:0]      rsp_event_y;
   logic signed [DX_W-1:0] rsp_event_dx;
   logic signed [DY_W-1:0] rsp_event_dy;
   logic [BTN_W-1:0]      rsp_event_buttons;
   logic [POS_W-1:0]      rsp_pointer_x;
   logic [POS_W-1:0]      rsp_pointer_y;
   logic [BTN_W-1:0]      rsp_pointer_buttons;
   logic                  rsp_packet_done;
   logic                  rsp_event_dropped;
   logic                  csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [DIM_W-1:0]      csr_write_data;

   ps2_mouse_packet_tracker i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_data_byte       (req_data_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_event_valid     (rsp_event_valid),
      .rsp_event_x         (rsp_event_x),
      .rsp_event_y         (rsp_event_y),
      .rsp_event_dx        (rsp_event_dx),
      .rsp_event_dy        (rsp_event_dy),
      .rsp_event_buttons   (rsp_event_buttons),
      .rsp_pointer_x       (rsp_pointer_x),
      .rsp_pointer_y       (rsp_pointer_y),
      .rsp_pointer_buttons (rsp_pointer_buttons),
      .rsp_packet_done     (rsp_packet_done),
      .rsp_event_dropped   (rsp_event_dropped),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   // ------------------------------------------------------------------
   // Tracker state as the testbench sees it: packet assembly, pointer,
   // buttons, the event ring and the screen size.
   // ------------------------------------------------------------------
   packet_state_type  pkt_phase;
   logic [BYTE_W-1:0] head_byte;
   logic [BYTE_W-1:0] dx_byte;
   int                cur_x;
   int                cur_y;
   logic [BTN_W-1:0]  cur_buttons;
   event_type         ring_slots [QDEPTH];
   int                ring_wr;
   int                ring_rd;
   int                view_width;
   int                view_height;

   // Reports the block owes us, oldest first.
   result_type pending_reports [$];

   int  mismatch_count = 0;
   int  items_sent;
   int  cycle_count = 0;
   int  stall_left = 0;
   bit  feed_gaps_on;
   bit  drain_stalls_on;
   bit  fling_on;
   logic [BYTE_W-1:0] fling_dx;
   logic [BYTE_W-1:0] fling_dy;

   // Directed opening: each row is one request, with a hand-typed report
   // where the answer is obvious from the reset state.
   typedef struct {
      logic [1:0]        op;
      logic [BYTE_W-1:0] data;
      bit                typed;
      result_type        want;
   } script_row_type;

   script_row_type opening_script [27];

   function automatic int clamp_dim(int v, int size);
      if (v < 0)
         return 0;
      if (v > size - 1)
         return size - 1;
      return v;
   endfunction

   // Apply a screen register write: saturate, ignore zero, pull the pointer
   // back inside the new bounds without recentering.
   function automatic void apply_screen(csr_index_type idx, logic [DIM_W-1:0] value);
      int v;
      v = (value > DIM_MAX) ? int'(DIM_MAX) : int'(value);
      if (v == 0)
         return;
      if (idx == CSR_SCREEN_WIDTH)
         view_width = v;
      else
         view_height = v;
      cur_x = clamp_dim(cur_x, view_width);
      cur_y = clamp_dim(cur_y, view_height);
   endfunction

   // Advance the tracker by one request and return the report it produces.
   function automatic result_type track_mouse_byte(logic [1:0] op, logic [BYTE_W-1:0] data);
      result_type r;
      int         dx;
      int         dy;
      int         nxt;
      r = '0;
      case (op)
         OP_DATA: begin
            case (pkt_phase)
               PKT_FIRST: begin
                  // Without the sync bit the byte cannot open a packet: drop it.
                  if ((data & SYNC_MASK) != 0) begin
                     head_byte = data;
                     pkt_phase = PKT_SECOND;
                  end
               end
               PKT_SECOND: begin
                  dx_byte   = data;
                  pkt_phase = PKT_THIRD;
               end
               default: begin
                  dx = int'($signed(dx_byte));
                  dy = -int'($signed(data));
                  pkt_phase = PKT_FIRST;
                  if ((head_byte & XOVF_MASK) != 0)
                     dx = 0;
                  if ((head_byte & YOVF_MASK) != 0)
                     dy = 0;
                  cur_x = clamp_dim(cur_x + dx, view_width);
                  cur_y = clamp_dim(cur_y + dy, view_height);
                  cur_buttons = BTN_W'(head_byte & BTN_MASK);
                  r.packet_done = 1'b1;
                  nxt = (ring_wr + 1) % QDEPTH;
                  if (nxt != ring_rd) begin
                     ring_slots[ring_wr] = '{x: POS_W'(cur_x), y: POS_W'(cur_y),
                                            dx: DX_W'(dx), dy: DY_W'(dy),
                                            buttons: cur_buttons};
                     ring_wr = nxt;
                  end else begin
                     r.event_dropped = 1'b1;
                  end
               end
            endcase
         end
         OP_READ: begin
            if (ring_rd != ring_wr) begin
               r.event_valid = 1'b1;
               r.evt = ring_slots[ring_rd];
               ring_rd = (ring_rd + 1) % QDEPTH;
            end
         end
         OP_RECENTER: begin
            cur_x = view_width / 2;
            cur_y = view_height / 2;
         end
         default: ;
      endcase
      r.pointer_x       = POS_W'(cur_x);
      r.pointer_y       = POS_W'(cur_y);
      r.pointer_buttons = cur_buttons;
      return r;
   endfunction

   // Build a report by hand for the directed rows.
   function automatic result_type shown(bit ev, event_type e, int px, int py, int btn, bit done);
      result_type r;
      r = '0;
      r.event_valid     = ev;
      r.evt             = e;
      r.pointer_x       = POS_W'(px);
      r.pointer_y       = POS_W'(py);
      r.pointer_buttons = BTN_W'(btn);
      r.packet_done     = done;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Offer one transaction, hold it until accepted, then log what it owes.
   task automatic send_req(logic [1:0] op, logic [BYTE_W-1:0] data, bit counted,
                           bit typed = 1'b0, result_type typed_want = '0);
      result_type want;
      if (feed_gaps_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_data_byte <= data;
      do @(posedge clock); while (!req_ready);
      // Always advance the tracker, even when the row carries its own answer.
      want = track_mouse_byte(op, data);
      pending_reports.push_back(typed ? typed_want : want);
      if (counted)
         items_sent++;
   endtask

   // One well-formed packet with random content; occasionally slip a read
   // or a recenter between its bytes, which must not disturb assembly.
   task automatic send_packet();
      logic [BYTE_W-1:0] head;
      logic [BYTE_W-1:0] mx;
      logic [BYTE_W-1:0] my;
      head = BYTE_W'($urandom) | SYNC_MASK;
      if (fling_on || $urandom_range(0, 7) != 0)
         head &= ~XOVF_MASK;
      if (fling_on || $urandom_range(0, 7) != 0)
         head &= ~YOVF_MASK;
      mx = fling_on ? fling_dx : BYTE_W'($urandom);
      my = fling_on ? fling_dy : BYTE_W'($urandom);
      send_req(OP_DATA, head, 1'b1);
      if ($urandom_range(0, 11) == 0)
         send_req($urandom_range(0, 1) ? OP_READ : OP_RECENTER, BYTE_W'($urandom), 1'b1);
      send_req(OP_DATA, mx, 1'b1);
      if ($urandom_range(0, 11) == 0)
         send_req($urandom_range(0, 1) ? OP_READ : OP_RECENTER, BYTE_W'($urandom), 1'b1);
      send_req(OP_DATA, my, 1'b1);
   endtask

   task automatic random_gesture();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
         send_packet();
      end else if (pick < 82) begin
         send_req(OP_READ, BYTE_W'($urandom), 1'b1);
      end else if (pick < 88) begin
         send_req(OP_RECENTER, BYTE_W'($urandom), 1'b1);
      end else if (pick < 94) begin
         // stray byte without the sync bit
         send_req(OP_DATA, BYTE_W'($urandom) & ~SYNC_MASK, 1'b0);
      end else if (pick < 97) begin
         send_req(OP_NONE, BYTE_W'($urandom), 1'b0);
      end else begin
         // truncated packet: leaves assembly mid-way and may misalign later bytes
         repeat ($urandom_range(1, 2)) send_req(OP_DATA, BYTE_W'($urandom), 1'b0);
      end
   endtask

   // Drop valid and wait until every owed report has come back, then let
   // the pipeline go quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0)
         @(posedge clock);
      repeat (LATENCY_SLACK) @(posedge clock);
   endtask

   // Overrun the ring with packets, pause until the block has answered
   // everything, then read it dry and past empty.
   task automatic flood_ring();
      repeat (QDEPTH + 12) send_packet();
      settle();
      repeat (QDEPTH + 2) send_req(OP_READ, BYTE_W'($urandom), 1'b1);
   endtask

   task automatic write_screen(csr_index_type idx, logic [DIM_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      apply_screen(idx, value);
   endtask

   // ------------------------------------------------------------------
   // Response side: random stall bursts on rsp_ready
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (drain_stalls_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 10);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic void check_field(string name, logic signed [15:0] want,
                                       logic signed [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Compare each accepted report with the oldest one owed.
   always @(posedge clock) begin
      result_type oldest;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: report with nothing expected, expected none, actual pointer (%0d,%0d)",
                     $time, rsp_pointer_x, rsp_pointer_y);
            mismatch_count++;
         end else begin
            oldest = pending_reports.pop_front();
            check_field("event_valid", oldest.event_valid, rsp_event_valid);
            check_field("event_x", oldest.evt.x, rsp_event_x);
            check_field("event_y", oldest.evt.y, rsp_event_y);
            check_field("event_dx", oldest.evt.dx, rsp_event_dx);
            check_field("event_dy", oldest.evt.dy, rsp_event_dy);
            check_field("event_buttons", oldest.evt.buttons, rsp_event_buttons);
            check_field("pointer_x", oldest.pointer_x, rsp_pointer_x);
            check_field("pointer_y", oldest.pointer_y, rsp_pointer_y);
            check_field("pointer_buttons", oldest.pointer_buttons, rsp_pointer_buttons);
            check_field("packet_done", oldest.packet_done, rsp_packet_done);
            check_field("event_dropped", oldest.event_dropped, rsp_event_dropped);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      event_type none_popped;
      event_type big_move;
      int        gesture_count;

      none_popped = '0;
      big_move    = '{x: 13'd767, y: 13'd488, dx: 8'sd127, dy: 9'sd128, buttons: 3'd7};

      // Reset state of the tracker.
      pkt_phase   = PKT_FIRST;
      head_byte   = '0;
      dx_byte     = '0;
      cur_x       = int'(RESET_POS_X);
      cur_y       = int'(RESET_POS_Y);
      cur_buttons = '0;
      ring_wr     = 0;
      ring_rd     = 0;
      view_width  = int'(RESET_WIDTH);
      view_height = int'(RESET_HEIGHT);
      feed_gaps_on    = 1'b1;
      drain_stalls_on = 1'b1;
      fling_on        = 1'b0;
      fling_dx        = 8'h7F;
      fling_dy        = 8'h80;

      // Screen 1280x720, pointer at (640,360), ring empty.
      opening_script[0]  = '{OP_READ,     8'h00, 1'b1, shown(0, none_popped, 640, 360, 0, 0)};
      // Bytes without the sync bit are dropped while no packet is open.
      opening_script[1]  = '{OP_DATA,     8'h00, 1'b1, shown(0, none_popped, 640, 360, 0, 0)};
      opening_script[2]  = '{OP_DATA,     8'hF7, 1'b1, shown(0, none_popped, 640, 360, 0, 0)};
      opening_script[3]  = '{OP_NONE,     8'hFF, 1'b1, shown(0, none_popped, 640, 360, 0, 0)};
      // Largest move: dx +127, dy byte -128 gives +128 down the screen.
      opening_script[4]  = '{OP_DATA,     8'h0F, 1'b1, shown(0, none_popped, 640, 360, 0, 0)};
      opening_script[5]  = '{OP_DATA,     8'h7F, 1'b1, shown(0, none_popped, 640, 360, 0, 0)};
      opening_script[6]  = '{OP_DATA,     8'h80, 1'b1, shown(0, none_popped, 767, 488, 7, 1)};
      opening_script[7]  = '{OP_READ,     8'h00, 1'b1, shown(1, big_move, 767, 488, 7, 0)};
      opening_script[8]  = '{OP_READ,     8'hFF, 1'b1, shown(0, none_popped, 767, 488, 7, 0)};
      // Both overflow flags: deltas become zero.
      opening_script[9]  = '{OP_DATA,     8'hC8, 1'b0, '0};
      opening_script[10] = '{OP_DATA,     8'h80, 1'b0, '0};
      opening_script[11] = '{OP_DATA,     8'h7F, 1'b0, '0};
      // Most negative dx and dy byte at +127.
      opening_script[12] = '{OP_DATA,     8'h09, 1'b0, '0};
      opening_script[13] = '{OP_DATA,     8'h80, 1'b0, '0};
      opening_script[14] = '{OP_DATA,     8'h7F, 1'b0, '0};
      // x overflow only
      opening_script[15] = '{OP_DATA,     8'h4A, 1'b0, '0};
      opening_script[16] = '{OP_DATA,     8'h01, 1'b0, '0};
      opening_script[17] = '{OP_DATA,     8'h01, 1'b0, '0};
      // y overflow only
      opening_script[18] = '{OP_DATA,     8'h8C, 1'b0, '0};
      opening_script[19] = '{OP_DATA,     8'hFF, 1'b0, '0};
      opening_script[20] = '{OP_DATA,     8'h00, 1'b0, '0};
      opening_script[21] = '{OP_RECENTER, 8'hA5, 1'b1, shown(0, none_popped, 640, 360, 4, 0)};
      opening_script[22] = '{OP_READ,     8'h00, 1'b0, '0};
      opening_script[23] = '{OP_READ,     8'h00, 1'b0, '0};
      opening_script[24] = '{OP_READ,     8'h00, 1'b0, '0};
      opening_script[25] = '{OP_READ,     8'h00, 1'b0, '0};
      opening_script[26] = '{OP_READ,     8'h00, 1'b0, '0};

      // Drive every input to a known value while reset is held, then release it.
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_opcode       <= OP_DATA;
      req_data_byte    <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_SCREEN_WIDTH;
      csr_write_data   <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_script[i])
         send_req(opening_script[i].op, opening_script[i].data, 1'b1,
                  opening_script[i].typed, opening_script[i].want);

      for (int phase = 1; phase <= LAST_PHASE; phase++) begin
         // Reprogram the screen only with nothing in flight.
         settle();
         case (phase)
            1: begin
               // one-pixel screen: everything clamps to the origin
               write_screen(CSR_SCREEN_WIDTH, 14'd1);
               write_screen(CSR_SCREEN_HEIGHT, 14'd1);
            end
            2: begin
               write_screen(CSR_SCREEN_WIDTH, DIM_MAX);
               write_screen(CSR_SCREEN_HEIGHT, DIM_MAX);
            end
            3: begin
               // zero is ignored, an all-ones value saturates
               write_screen(CSR_SCREEN_WIDTH, 14'd0);
               write_screen(CSR_SCREEN_HEIGHT, 14'h3FFF);
               write_screen(CSR_SCREEN_WIDTH, 14'd3);
            end
            4: begin
               write_screen(CSR_SCREEN_WIDTH, DIM_W'($urandom_range(1, 400)));
               write_screen(CSR_SCREEN_HEIGHT, DIM_W'($urandom_range(1, 400)));
            end
            5: begin
               write_screen(CSR_SCREEN_WIDTH, DIM_W'($urandom));
               write_screen(CSR_SCREEN_HEIGHT, DIM_W'($urandom));
            end
            default: begin
               write_screen(CSR_SCREEN_WIDTH, RESET_WIDTH);
               write_screen(CSR_SCREEN_HEIGHT, RESET_HEIGHT);
            end
         endcase
         csr_write_enable <= 1'b0;

         items_sent    = 0;
         gesture_count = 0;
         if (phase == 2 || phase == 4)
            flood_ring();
         while (items_sent < PHASE_ITEMS) begin
            // Re-roll idling and pointer flings now and then, so stretches
            // with and without gaps both occur. The last phase runs flat out.
            if (gesture_count % 32 == 0) begin
               feed_gaps_on    = (phase != LAST_PHASE) && ($urandom_range(0, 3) != 0);
               drain_stalls_on = (phase != LAST_PHASE) && ($urandom_range(0, 3) != 0);
               fling_on        = ($urandom_range(0, 2) == 0);
               fling_dx        = $urandom_range(0, 1) ? 8'h7F : 8'h80;
               fling_dy        = $urandom_range(0, 1) ? 8'h7F : 8'h80;
            end
            random_gesture();
            gesture_count++;
         end
      end

      settle();
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
